FILE: hw/rtl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

  // storage shape
  localparam int DEPTH    = 16;
  localparam int KEY_BITS = 32;
  localparam int PRIO_W   = 16;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_FIND   = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_REVIEW = 2'd3;

  // status codes
  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_ZERO_PRIO = 3'd1;
  localparam logic [2:0] STS_FULL      = 3'd2;
  localparam logic [2:0] STS_NOT_FOUND = 3'd3;
  localparam logic [2:0] STS_EMPTY     = 3'd4;

  // cell operation codes
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_ROTATE = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [31:0]        name_key;
    logic signed [15:0] priority_req;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [31:0]        entry_key;
    logic signed [15:0] entry_priority;
    logic [4:0]         entry_count;
    logic               last_of_run;
  } out_beat_t;

  // contents of one cell
  typedef struct packed {
    logic [KEY_BITS-1:0]      key;
    logic signed [PRIO_W-1:0] prio;
  } cell_data_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic [1:0]               op;
    logic [KEY_BITS-1:0]      key;
    logic signed [PRIO_W-1:0] prio;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic               occ,
  input  logic               is_last,
  input  logic               ge_in,
  output logic               ge_out,
  input  logic               hit_in,
  output logic               hit_out,
  input  spq_pkg::cell_data_t found_in,
  output spq_pkg::cell_data_t found_out,
  input  spq_pkg::cell_data_t prev_data,
  input  spq_pkg::cell_data_t next_data,
  input  spq_pkg::cell_data_t head_data,
  output spq_pkg::cell_data_t data
);

  spq_pkg::cell_data_t data_r;
  spq_pkg::cell_data_t data_nxt;
  logic                ge_own;
  logic                match;

  assign data = data_r;

  // an empty cell counts as greater or equal, so the insert point is found
  assign ge_own  = !occ || (data_r.prio >= ctl.prio);
  assign ge_out  = ge_own;

  // first match travels down the chain
  assign match     = occ && (data_r.key == ctl.key);
  assign hit_out   = hit_in || match;
  assign found_out = hit_in ? found_in : data_r;

  // next contents
  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      spq_pkg::OP_INSERT: begin
        if (ge_in) begin
          data_nxt = prev_data;
        end else if (ge_own) begin
          data_nxt.key  = ctl.key;
          data_nxt.prio = ctl.prio;
        end
      end
      spq_pkg::OP_REMOVE: begin
        if (hit_out) begin
          data_nxt = next_data;
        end
      end
      spq_pkg::OP_ROTATE: begin
        if (is_last) begin
          data_nxt = head_data;
        end else if (occ) begin
          data_nxt = next_data;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

FILE: hw/rtl/sorted_priority_queue.sv
`timescale 1ns / 1ps
// Sorted priority queue: up to DEPTH (key, priority) entries held in a row of
// cells in ascending priority order, newest first among equal priorities.
// Input channel in_valid / in_stall / in_data carries one command beat:
// insert, find, delete or review. Result channel out_valid / out_stall /
// out_data returns the result beats; last_of_run marks the final one.
// One command is worked at a time. Insert and find latch the command, then
// the cells compare and shift in parallel as the result is loaded into the
// output register. Delete removes the first matching cell per cycle while
// any match is left, then gives its result. Review rotates the row through
// cell 0, one beat per cycle while the output is not stalled, occupancy
// beats in all, which leaves the order unchanged. The next command is
// accepted in the cycle after the previous one's last result is registered.
// Reset empties the queue (occupancy zero) and drops any pending result.
// A stalled result beat holds in the output register; the block waits
// there until it can load the next one.
module sorted_priority_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  spq_pkg::in_beat_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output spq_pkg::out_beat_t out_data
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_REVIEW = 2'd2;

  localparam int CW = spq_pkg::CNT_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(spq_pkg::DEPTH);

  logic [1:0]             state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          rev_r, rev_nxt;
  logic                   del_hit_r, del_hit_nxt;
  logic                   out_valid_r, out_valid_nxt;
  spq_pkg::out_beat_t     out_data_r;
  spq_pkg::in_beat_t      cmd_r;

  logic                   out_free;
  logic                   emit;
  spq_pkg::out_beat_t     emit_data;
  spq_pkg::cell_ctl_t     ctl;

  spq_pkg::cell_data_t    data_w  [spq_pkg::DEPTH];
  spq_pkg::cell_data_t    found_w [spq_pkg::DEPTH+1];
  logic [spq_pkg::DEPTH:0] ge_w;
  logic [spq_pkg::DEPTH:0] hit_w;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // row of cells
  assign ge_w[0]    = 1'b0;
  assign hit_w[0]   = 1'b0;
  assign found_w[0] = '0;

  for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
    spq_pkg::cell_data_t prev_d;
    spq_pkg::cell_data_t next_d;
    if (i == 0) begin : g_first
      assign prev_d = '0;
    end else begin : g_mid
      assign prev_d = data_w[i-1];
    end
    if (i == spq_pkg::DEPTH - 1) begin : g_end
      assign next_d = '0;
    end else begin : g_more
      assign next_d = data_w[i+1];
    end
    spq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (CW'(i) < count_r),
      .is_last   (CW'(i + 1) == count_r),
      .ge_in     (ge_w[i]),
      .ge_out    (ge_w[i+1]),
      .hit_in    (hit_w[i]),
      .hit_out   (hit_w[i+1]),
      .found_in  (found_w[i]),
      .found_out (found_w[i+1]),
      .prev_data (prev_d),
      .next_data (next_d),
      .head_data (data_w[0]),
      .data      (data_w[i])
    );
  end

  // command sequencing
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    rev_nxt     = rev_r;
    del_hit_nxt = del_hit_r;
    emit        = 1'b0;
    emit_data   = '0;
    ctl.op      = spq_pkg::OP_HOLD;
    ctl.key     = cmd_r.name_key[spq_pkg::KEY_BITS-1:0];
    ctl.prio    = cmd_r.priority_req;
    emit_data.last_of_run = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt   = S_EXEC;
          del_hit_nxt = 1'b0;
          rev_nxt     = '0;
        end
      end
      S_EXEC: begin
        case (cmd_r.cmd)
          spq_pkg::CMD_INSERT: begin
            if (out_free) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
              if (cmd_r.priority_req == '0) begin
                emit_data.status = spq_pkg::STS_ZERO_PRIO;
              end else if (count_r >= FULL_CNT) begin
                emit_data.status = spq_pkg::STS_FULL;
              end else begin
                ctl.op    = spq_pkg::OP_INSERT;
                count_nxt = count_r + CW'(1);
                emit_data.status = spq_pkg::STS_OK;
              end
            end
          end
          spq_pkg::CMD_FIND: begin
            if (out_free) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
              if (count_r == '0) begin
                emit_data.status = spq_pkg::STS_EMPTY;
              end else if (hit_w[spq_pkg::DEPTH]) begin
                emit_data.status         = spq_pkg::STS_OK;
                emit_data.entry_key      = 32'(found_w[spq_pkg::DEPTH].key);
                emit_data.entry_priority = found_w[spq_pkg::DEPTH].prio;
              end else begin
                emit_data.status = spq_pkg::STS_NOT_FOUND;
              end
            end
          end
          spq_pkg::CMD_DELETE: begin
            if (count_r != '0 && hit_w[spq_pkg::DEPTH]) begin
              // drop the first matching cell, look again next cycle
              ctl.op      = spq_pkg::OP_REMOVE;
              count_nxt   = count_r - CW'(1);
              del_hit_nxt = 1'b1;
            end else if (out_free) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
              if (count_r == '0 && !del_hit_r) begin
                emit_data.status = spq_pkg::STS_EMPTY;
              end else if (del_hit_r) begin
                emit_data.status = spq_pkg::STS_OK;
              end else begin
                emit_data.status = spq_pkg::STS_NOT_FOUND;
              end
            end
          end
          spq_pkg::CMD_REVIEW: begin
            if (count_r == '0) begin
              if (out_free) begin
                emit             = 1'b1;
                emit_data.status = spq_pkg::STS_EMPTY;
                state_nxt        = S_IDLE;
              end
            end else begin
              state_nxt = S_REVIEW;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_REVIEW: begin
        if (out_free) begin
          emit   = 1'b1;
          ctl.op = spq_pkg::OP_ROTATE;
          emit_data.status         = spq_pkg::STS_OK;
          emit_data.entry_key      = 32'(data_w[0].key);
          emit_data.entry_priority = data_w[0].prio;
          emit_data.last_of_run    = (rev_r + CW'(1) == count_r);
          rev_nxt = rev_r + CW'(1);
          if (rev_r + CW'(1) == count_r) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    emit_data.entry_count = 5'(count_nxt);
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rev_r       <= '0;
      del_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rev_r       <= rev_nxt;
      del_hit_r   <= del_hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // beat payloads
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      cmd_r <= in_data;
    end
    if (emit) begin
      out_data_r <= emit_data;
    end
  end

endmodule
